>>> rtl/fgp_pkg.sv
// ----------------------------------------------------------------------------
// fgp_pkg
// Shared types, constants and CORDIC tables for the formation goal controller.
// ----------------------------------------------------------------------------
package fgp_pkg;

	localparam int XW = 40;          // position datapath, Q.24
	localparam int ZW = 36;          // angle datapath, Q.30 radians
	localparam int PW = 16;          // port field width
	localparam int TAB_LEN = 25;
	localparam int CORDIC_ITERATIONS_DEF = 16;
	localparam int KW = 30;
	localparam int POS_SHIFT = 13;   // Q5.11 -> Q.24
	localparam int ANG_SHIFT = 17;   // Q3.13 -> Q.30

	localparam logic [KW-1:0] KINV_Q30 = 30'd652032874;
	localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;

	typedef enum logic [2:0] {
		REG_OFFSET_A_X = 3'd0,
		REG_OFFSET_A_Y = 3'd1,
		REG_OFFSET_B_X = 3'd2,
		REG_OFFSET_B_Y = 3'd3,
		REG_GAIN_LINEAR = 3'd4,
		REG_GAIN_ANGULAR = 3'd5,
		REG_DISTANCE_LIMIT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		case (i)
			0: return 36'h03243F6A8;
			1: return 36'h01DAC6705;
			2: return 36'h00FADBAFC;
			3: return 36'h007F56EA6;
			4: return 36'h003FEAB76;
			5: return 36'h001FFD55B;
			6: return 36'h000FFFAAA;
			7: return 36'h0007FFF55;
			8: return 36'h0003FFFEA;
			9: return 36'h0001FFFFD;
			10: return 36'h0000FFFFF;
			11: return 36'h00007FFFF;
			12: return 36'h00003FFFF;
			13: return 36'h00001FFFF;
			14: return 36'h00000FFFF;
			15: return 36'h000007FFF;
			16: return 36'h000003FFF;
			17: return 36'h000001FFF;
			18: return 36'h000000FFF;
			19: return 36'h0000007FF;
			20: return 36'h0000003FF;
			21: return 36'h0000001FF;
			22: return 36'h0000000FF;
			23: return 36'h00000007F;
			24: return 36'h00000003F;
			default: return '0;
		endcase
	endfunction

	// fold angles beyond a quarter turn by flipping the vector
	function automatic vec_t rot_fold(input vec_t v);
		vec_t r;
		r = v;
		if (v.z > HALF_PI_Q30) begin
			r.x = -v.x;
			r.y = -v.y;
			r.z = v.z - PI_Q30;
		end else if (v.z < -HALF_PI_Q30) begin
			r.x = -v.x;
			r.y = -v.y;
			r.z = v.z + PI_Q30;
		end
		return r;
	endfunction

endpackage

>>> rtl/formation_goal_p_controller_core.sv
// ----------------------------------------------------------------------------
// formation_goal_p_controller_core
// Go-to-goal P controller for a formation follower, fully pipelined CORDIC.
// ----------------------------------------------------------------------------
// Channel   Ports                                              Dir  Handshake
// command   start, busy, follower_select, leader_*, follower_*  in  start & !busy
// result    done, linear_speed, angular_rate                    out  done strobe
// config    wr_en, wr_index, wr_data                             in  wr_en
//
// One pose pair enters per cycle; busy never rises.
// Three unrolled CORDIC chains (goal rotation, body-frame rotation,
// vectoring), each followed by a two-stage gain removal, plus input, error
// sum, vectoring setup, clamp, multiply and output registers.
// Reset clears valid bits and loads register defaults. Results cannot be
// stalled; each one shows for a single cycle with done.
// ----------------------------------------------------------------------------
module formation_goal_p_controller_core
	import fgp_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 follower_select,
	input  logic signed [PW-1:0] leader_x,
	input  logic signed [PW-1:0] leader_y,
	input  logic signed [PW-1:0] leader_heading,
	input  logic signed [PW-1:0] follower_x,
	input  logic signed [PW-1:0] follower_y,
	input  logic signed [PW-1:0] follower_heading,
	output logic                 done,
	output logic        [PW-1:0] linear_speed,
	output logic signed [PW-1:0] angular_rate,
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [PW-1:0]        wr_data
);

	localparam int DW = PW + 1;
	localparam int SBA = 1 + DW + DW + PW;
	localparam int MW = 29;
	localparam int LPW = MW + PW;
	localparam int RPW = ZW + PW + 1;

	// configuration registers
	logic signed [PW-1:0] offa_x_q, offa_y_q, offb_x_q, offb_y_q;
	logic [PW-1:0] gain_lin_q, gain_ang_q;
	logic [14:0] dist_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offa_x_q <= -16'sd2048;
			offa_y_q <= -16'sd2048;
			offb_x_q <= -16'sd2048;
			offb_y_q <= 16'sd2048;
			gain_lin_q <= 16'd6144;
			gain_ang_q <= 16'd16384;
			dist_lim_q <= 15'd4096;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_OFFSET_A_X: offa_x_q <= wr_data;
				REG_OFFSET_A_Y: offa_y_q <= wr_data;
				REG_OFFSET_B_X: offb_x_q <= wr_data;
				REG_OFFSET_B_Y: offb_y_q <= wr_data;
				REG_GAIN_LINEAR: gain_lin_q <= wr_data;
				REG_GAIN_ANGULAR: gain_ang_q <= wr_data;
				REG_DISTANCE_LIMIT: dist_lim_q <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: capture the command beat
	logic v_s1, sel_s1;
	logic signed [PW-1:0] lx_s1, ly_s1, lh_s1, fx_s1, fy_s1, fh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		sel_s1 <= follower_select;
		lx_s1 <= leader_x;
		ly_s1 <= leader_y;
		lh_s1 <= leader_heading;
		fx_s1 <= follower_x;
		fy_s1 <= follower_y;
		fh_s1 <= follower_heading;
	end

	vec_t va_raw, va_in, va_out;
	logic signed [DW-1:0] dx_a, dy_a;

	always_comb begin
		va_raw.x = XW'(sel_s1 ? offb_x_q : offa_x_q) <<< POS_SHIFT;
		va_raw.y = XW'(sel_s1 ? offb_y_q : offa_y_q) <<< POS_SHIFT;
		va_raw.z = ZW'(lh_s1) <<< ANG_SHIFT;
		va_in = rot_fold(va_raw);
		dx_a = DW'(lx_s1) - DW'(fx_s1);
		dy_a = DW'(ly_s1) - DW'(fy_s1);
	end

	// goal offset rotated into the world frame
	fgp_cordic #(.ITER(CORDIC_ITERATIONS), .VEC(1'b0)) u_cordic_a (
		.clk(clk), .v_i(va_in), .v_o(va_out)
	);

	logic signed [XW-1:0] ux_a, uy_a;
	fgp_unscale u_unscale_ax (.clk(clk), .v_i(va_out.x), .u_o(ux_a));
	fgp_unscale u_unscale_ay (.clk(clk), .v_i(va_out.y), .u_o(uy_a));

	logic v_au;
	logic signed [DW-1:0] dx_au, dy_au;
	logic signed [PW-1:0] fh_au;
	fgp_delay #(.DEPTH(CORDIC_ITERATIONS + 2), .W(SBA)) u_delay_a (
		.clk(clk), .arst_n(arst_n),
		.d({v_s1, dx_a, dy_a, fh_s1}),
		.q({v_au, dx_au, dy_au, fh_au})
	);

	// stage 2: goal error in world frame
	logic v_s2;
	vec_t vb_s2, vb_in, vb_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_au;
	end

	always_ff @(posedge clk) begin
		vb_s2.x <= ux_a + (XW'(dx_au) <<< POS_SHIFT);
		vb_s2.y <= uy_a + (XW'(dy_au) <<< POS_SHIFT);
		vb_s2.z <= -(ZW'(fh_au) <<< ANG_SHIFT);
	end

	assign vb_in = rot_fold(vb_s2);

	// error rotated into the follower body frame
	fgp_cordic #(.ITER(CORDIC_ITERATIONS), .VEC(1'b0)) u_cordic_b (
		.clk(clk), .v_i(vb_in), .v_o(vb_out)
	);

	logic signed [XW-1:0] ux_b, uy_b;
	fgp_unscale u_unscale_bx (.clk(clk), .v_i(vb_out.x), .u_o(ux_b));
	fgp_unscale u_unscale_by (.clk(clk), .v_i(vb_out.y), .u_o(uy_b));

	logic v_bu;
	fgp_delay #(.DEPTH(CORDIC_ITERATIONS + 2), .W(1)) u_delay_b (
		.clk(clk), .arst_n(arst_n), .d(v_s2), .q(v_bu)
	);

	// stage 3: vectoring setup, backward vectors flipped with a half turn
	logic v_s3, zero_s3;
	vec_t vc_s3, vc_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_bu;
	end

	always_ff @(posedge clk) begin
		zero_s3 <= (ux_b == '0) && (uy_b == '0);
		if (ux_b < 0) begin
			vc_s3.x <= -ux_b;
			vc_s3.y <= -uy_b;
			vc_s3.z <= (uy_b >= 0) ? PI_Q30 : -PI_Q30;
		end else begin
			vc_s3.x <= ux_b;
			vc_s3.y <= uy_b;
			vc_s3.z <= '0;
		end
	end

	fgp_cordic #(.ITER(CORDIC_ITERATIONS), .VEC(1'b1)) u_cordic_c (
		.clk(clk), .v_i(vc_s3), .v_o(vc_out)
	);

	logic v_cc, zero_cc;
	fgp_delay #(.DEPTH(CORDIC_ITERATIONS), .W(2)) u_delay_c (
		.clk(clk), .arst_n(arst_n), .d({v_s3, zero_s3}), .q({v_cc, zero_cc})
	);

	logic signed [XW-1:0] mag_cu;
	fgp_unscale u_unscale_c (.clk(clk), .v_i(vc_out.x), .u_o(mag_cu));

	logic v_cu, zero_cu;
	logic signed [ZW-1:0] ang_cu;
	fgp_delay #(.DEPTH(2), .W(2 + ZW)) u_delay_z (
		.clk(clk), .arst_n(arst_n),
		.d({v_cc, zero_cc, vc_out.z}),
		.q({v_cu, zero_cu, ang_cu})
	);

	// stage 4: distance clamp
	logic v_s4;
	logic [MW-1:0] magc_s4, lim;
	logic signed [ZW-1:0] ang_s4;

	assign lim = {1'b0, dist_lim_q, 13'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_cu;
	end

	always_ff @(posedge clk) begin
		if (mag_cu < 0) magc_s4 <= '0;
		else if (mag_cu > $signed(XW'(lim))) magc_s4 <= lim;
		else magc_s4 <= mag_cu[MW-1:0];
		ang_s4 <= zero_cu ? '0 : ang_cu;
	end

	// stage 5: gains
	logic v_s5;
	logic [LPW-1:0] lin_s5;
	logic signed [RPW-1:0] rate_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		lin_s5 <= magc_s4 * gain_lin_q;
		rate_s5 <= ang_s4 * $signed({1'b0, gain_ang_q});
	end

	// round half up to Q5.11 and saturate
	logic [LPW-1:0] lin_sum;
	logic [LPW-26:0] lin_r;
	logic signed [RPW-1:0] rate_sum;
	logic signed [RPW-32:0] rate_r;

	always_comb begin
		lin_sum = lin_s5 + (LPW'(1) << 24);
		lin_r = lin_sum[LPW-1:25];
		rate_sum = rate_s5 + (RPW'(1) <<< 30);
		rate_r = rate_sum[RPW-1:31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s5;
	end

	always_ff @(posedge clk) begin
		linear_speed <= (lin_r > (LPW-25)'(16'hFFFF)) ? 16'hFFFF : lin_r[PW-1:0];
		if (rate_r > (RPW-31)'(32767)) angular_rate <= 16'sh7FFF;
		else if (rate_r < -(RPW-31)'(32768)) angular_rate <= 16'sh8000;
		else angular_rate <= rate_r[PW-1:0];
	end

	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		v_cu && zero_cu |-> mag_cu == '0)
		else $error("zero error vector gave nonzero distance");

	a_vec_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !zero_s3 |-> vc_s3.x >= 0)
		else $error("vectoring input not in right half plane");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> magc_s4 <= lim)
		else $error("clamped distance above limit");

endmodule

>>> rtl/fgp_delay.sv
// ----------------------------------------------------------------------------
// fgp_delay
// Shift line that keeps valid and side data aligned with a datapath.
// ----------------------------------------------------------------------------
module fgp_delay #(
	parameter int DEPTH = 2,
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) pipe_q[i] <= '0;
		end else begin
			pipe_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule

>>> rtl/fgp_cordic.sv
// ----------------------------------------------------------------------------
// fgp_cordic
// Unrolled CORDIC, one registered iteration per stage; rotation or vectoring.
// ----------------------------------------------------------------------------
module fgp_cordic
	import fgp_pkg::*;
#(
	parameter int ITER = CORDIC_ITERATIONS_DEF,
	parameter bit VEC = 1'b0
) (
	input  logic clk,
	input  vec_t v_i,
	output vec_t v_o
);

	vec_t v_s [ITER];

	for (genvar i = 0; i < ITER; i++) begin : g_it
		vec_t vp;
		logic sub;
		if (i == 0) begin : g_first
			assign vp = v_i;
		end else begin : g_next
			assign vp = v_s[i-1];
		end
		// vectoring drives y to zero, rotation drives z to zero
		assign sub = VEC ? (vp.y < 0) : (vp.z >= 0);
		always_ff @(posedge clk) begin
			if (sub) begin
				v_s[i].x <= vp.x - (vp.y >>> i);
				v_s[i].y <= vp.y + (vp.x >>> i);
				v_s[i].z <= vp.z - atan_q30(i);
			end else begin
				v_s[i].x <= vp.x + (vp.y >>> i);
				v_s[i].y <= vp.y - (vp.x >>> i);
				v_s[i].z <= vp.z + atan_q30(i);
			end
		end
	end

	assign v_o = v_s[ITER-1];

endmodule

>>> rtl/fgp_unscale.sv
// ----------------------------------------------------------------------------
// fgp_unscale
// Removes the CORDIC gain: round(v * 1/K), two stages, split multiply.
// ----------------------------------------------------------------------------
module fgp_unscale
	import fgp_pkg::*;
(
	input  logic                 clk,
	input  logic signed [XW-1:0] v_i,
	output logic signed [XW-1:0] u_o
);

	localparam int LOW = 20;
	localparam int HW = XW - LOW;
	localparam int SW = XW + KW + 2;

	logic signed [HW+KW:0]  ph_s1;
	logic        [LOW+KW-1:0] pl_s1;
	logic signed [SW-1:0]   sum;

	always_ff @(posedge clk) begin
		ph_s1 <= $signed(v_i[XW-1:LOW]) * $signed({1'b0, KINV_Q30});
		pl_s1 <= v_i[LOW-1:0] * KINV_Q30;
	end

	assign sum = (SW'(ph_s1) <<< LOW) + $signed(SW'(pl_s1)) + (SW'(1) <<< (KW - 1));

	always_ff @(posedge clk) begin
		u_o <= sum[XW+KW-1:KW];
	end

endmodule

>>> verif/tb_formation_goal_p_controller_core.sv
// ----------------------------------------------------------------------------
// tb_formation_goal_p_controller_core
// Drives pose pairs through the formation controller and checks every speed
// and turn-rate result against a bit-exact CORDIC predictor kept in the bench.
// ----------------------------------------------------------------------------
class goal_scoreboard;
	logic [15:0] speed_q[$];
	logic [15:0] rate_q[$];
	int errors;

	function void note(logic [15:0] spd, logic [15:0] rt);
		speed_q.push_back(spd);
		rate_q.push_back(rt);
	endfunction

	function void check(logic [15:0] spd, logic [15:0] rt);
		logic [15:0] es;
		logic [15:0] er;
		if (speed_q.size() == 0) begin
			$error("unexpected result beat speed=%0d rate=%0d", spd, rt);
			errors++;
			return;
		end
		es = speed_q.pop_front();
		er = rate_q.pop_front();
		if (es !== spd) begin
			$error("linear_speed expected %0d actual %0d", es, spd);
			errors++;
		end
		if (er !== rt) begin
			$error("angular_rate expected %0d actual %0d", $signed(er), $signed(rt));
			errors++;
		end
	endfunction

	function int pending();
		return speed_q.size();
	endfunction
endclass

module tb_formation_goal_p_controller_core;
	import fgp_pkg::*;

	localparam int ITERS = 16;
	localparam int LATENCY = 3 * ITERS + 12;
	localparam longint PI_C = 64'sd3373259426;
	localparam longint HALF_PI_C = 64'sd1686629713;
	localparam longint KINV_C = 64'sd652032874;
	localparam longint LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic follower_select = 1'b0;
	logic signed [15:0] leader_x = '0, leader_y = '0, leader_heading = '0;
	logic signed [15:0] follower_x = '0, follower_y = '0, follower_heading = '0;
	logic done;
	logic [15:0] linear_speed;
	logic signed [15:0] angular_rate;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [15:0] wr_data = '0;

	goal_scoreboard sb;
	logic [15:0] cfg_regs[7];
	int send_idle_pct;
	longint cycles = 0;

	formation_goal_p_controller_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL formation_goal_p_controller_core");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n && done) sb.check(linear_speed, angular_rate);

	function automatic longint atan_at(int i);
		longint t[25] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
			64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
			64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
			64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
			64'h0000003F};
		return t[i];
	endfunction

	// >>> on a signed longint is a floor shift
	function automatic longint gain_fix(longint v);
		return (v * KINV_C + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void cordic_rotate(inout longint x, inout longint y, input longint z);
		longint dx, dy;
		if (z > HALF_PI_C) begin
			x = -x; y = -y; z -= PI_C;
		end else if (z < -HALF_PI_C) begin
			x = -x; y = -y; z += PI_C;
		end
		for (int i = 0; i < ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_at(i);
			end else begin
				x += dx; y -= dy; z += atan_at(i);
			end
		end
		x = gain_fix(x);
		y = gain_fix(y);
	endfunction

	function automatic void predict_command(logic sel, logic signed [15:0] lx, ly, lh,
			fx, fy, fh, output logic [15:0] spd, output logic [15:0] rt);
		longint ox, oy, ex, ey, z, dx, dy, mag, lin, rate;
		ox = longint'($signed(sel ? cfg_regs[REG_OFFSET_B_X] : cfg_regs[REG_OFFSET_A_X])) * 8192;
		oy = longint'($signed(sel ? cfg_regs[REG_OFFSET_B_Y] : cfg_regs[REG_OFFSET_A_Y])) * 8192;
		cordic_rotate(ox, oy, longint'(lh) * 131072);
		ex = ox + longint'(lx) * 8192 - longint'(fx) * 8192;
		ey = oy + longint'(ly) * 8192 - longint'(fy) * 8192;
		cordic_rotate(ex, ey, -(longint'(fh) * 131072));
		if (ex == 0 && ey == 0) begin
			mag = 0; z = 0;
		end else begin
			z = 0;
			// backward-pointing error: flip and seed the angle with +-pi
			if (ex < 0) begin
				z = (ey >= 0) ? PI_C : -PI_C;
				ex = -ex; ey = -ey;
			end
			for (int i = 0; i < ITERS; i++) begin
				dx = ey >>> i;
				dy = ex >>> i;
				if (ey < 0) begin
					ex -= dx; ey += dy; z -= atan_at(i);
				end else begin
					ex += dx; ey -= dy; z += atan_at(i);
				end
			end
			mag = gain_fix(ex);
		end
		if (mag > longint'(cfg_regs[REG_DISTANCE_LIMIT]) * 8192)
			mag = longint'(cfg_regs[REG_DISTANCE_LIMIT]) * 8192;
		if (mag < 0) mag = 0;
		lin = (mag * longint'(cfg_regs[REG_GAIN_LINEAR]) + (64'sd1 <<< 24)) >>> 25;
		if (lin > 65535) lin = 65535;
		if (lin < 0) lin = 0;
		rate = (z * longint'(cfg_regs[REG_GAIN_ANGULAR]) + (64'sd1 <<< 30)) >>> 31;
		if (rate > 32767) rate = 32767;
		if (rate < -32768) rate = -32768;
		spd = lin[15:0];
		rt = rate[15:0];
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		cfg_regs[idx] = (idx == REG_DISTANCE_LIMIT) ? {1'b0, val[14:0]} : val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// one beat; start stays high across back-to-back beats
	task automatic send_command(logic sel, logic signed [15:0] lx, ly, lh, fx, fy, fh);
		logic [15:0] spd, rt;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		follower_select <= sel;
		leader_x <= lx; leader_y <= ly; leader_heading <= lh;
		follower_x <= fx; follower_y <= fy; follower_heading <= fh;
		do @(posedge clk); while (busy);
		predict_command(sel, lx, ly, lh, fx, fy, fh, spd, rt);
		sb.note(spd, rt);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_heading();
		return 16'($signed($urandom_range(51472)) - 25736);
	endfunction

	function automatic logic signed [15:0] rand_pos(bit near);
		if (near) return 16'($signed($urandom_range(16384)) - 8192);
		return 16'($urandom);
	endfunction

	task automatic random_phase(int n, int idle);
		bit near;
		logic signed [15:0] lx, ly;
		send_idle_pct = idle;
		for (int k = 0; k < n; k++) begin
			near = $urandom_range(3) != 0;
			lx = rand_pos(near);
			ly = rand_pos(near);
			if (near && $urandom_range(9) == 0)
				send_command(1'($urandom_range(1)), lx, ly, rand_heading(),
					lx + 16'($signed($urandom_range(6)) - 3),
					ly + 16'($signed($urandom_range(6)) - 3), rand_heading());
			else
				send_command(1'($urandom_range(1)), lx, ly, rand_heading(),
					rand_pos(near), rand_pos(near), rand_heading());
		end
		start <= 1'b0;
	endtask

	task automatic random_config();
		write_reg(REG_OFFSET_A_X, 16'($signed($urandom_range(8192)) - 4096));
		write_reg(REG_OFFSET_A_Y, 16'($urandom));
		write_reg(REG_OFFSET_B_X, 16'($signed($urandom_range(8192)) - 4096));
		write_reg(REG_OFFSET_B_Y, 16'($urandom));
		write_reg(REG_GAIN_LINEAR, 16'($urandom));
		write_reg(REG_GAIN_ANGULAR, 16'($urandom_range(32768)));
		write_reg(REG_DISTANCE_LIMIT, 16'($urandom_range(32767)));
	endtask

	initial begin
		sb = new();
		cfg_regs[REG_OFFSET_A_X] = 16'hF800;
		cfg_regs[REG_OFFSET_A_Y] = 16'hF800;
		cfg_regs[REG_OFFSET_B_X] = 16'hF800;
		cfg_regs[REG_OFFSET_B_Y] = 16'd2048;
		cfg_regs[REG_GAIN_LINEAR] = 16'd6144;
		cfg_regs[REG_GAIN_ANGULAR] = 16'd16384;
		cfg_regs[REG_DISTANCE_LIMIT] = 16'd4096;
		send_idle_pct = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset config, extremes, backward error, wide headings
		send_command(0, 0, 0, 0, 0, 0, 0);
		send_command(1, 0, 0, 0, 0, 0, 0);
		send_command(0, 16'sh0800, 16'sh0800, 0, 0, 16'sh0800, 0);
		send_command(0, 16'sh0000, 16'sh0800, 0, -16'sh0800, 16'sh1000, 0);
		send_command(1, 16'sh7FFF, 16'sh7FFF, 16'sd25736, -16'sh8000, -16'sh8000, -16'sd25736);
		send_command(0, -16'sh8000, -16'sh8000, -16'sd25736, 16'sh7FFF, 16'sh7FFF, 16'sd25736);
		send_command(1, 16'sh1000, -16'sh1000, 16'sd12868, 16'sh0000, 16'sh0000, -16'sd12868);
		send_command(0, -16'sh1000, 16'sh0000, 16'sd20000, 16'sh2000, 16'sh0100, 16'sd13000);
		send_command(1, 16'sh0000, 16'sh0000, -16'sd13000, 16'sh0400, -16'sh0400, 16'sd25000);
		start <= 1'b0;
		drain();

		// extremes: zero offsets (zero error), max gains and limit
		write_reg(REG_OFFSET_A_X, 16'h0000);
		write_reg(REG_OFFSET_A_Y, 16'h0000);
		write_reg(REG_OFFSET_B_X, 16'h7FFF);
		write_reg(REG_OFFSET_B_Y, 16'h8000);
		write_reg(REG_GAIN_LINEAR, 16'hFFFF);
		write_reg(REG_GAIN_ANGULAR, 16'hFFFF);
		write_reg(REG_DISTANCE_LIMIT, 16'h7FFF);
		send_command(0, 16'sh1234, -16'sh0567, 16'sd7000, 16'sh1234, -16'sh0567, -16'sd9000);
		send_command(0, 16'sh1000, 16'sh0000, 0, 16'sh1001, 16'sh0000, 0);
		send_command(1, 16'sh7FFF, -16'sh8000, 16'sd25736, -16'sh8000, 16'sh7FFF, 0);
		send_command(1, -16'sh8000, 16'sh7FFF, -16'sd25736, 16'sh7FFF, -16'sh8000, 16'sd25736);
		send_command(0, 0, 16'sh0001, 0, 0, 0, 0);
		send_command(0, 0, -16'sh0001, 0, 16'sh0001, 0, 0);
		start <= 1'b0;
		drain();
		write_reg(REG_OFFSET_A_X, 16'h8000);
		write_reg(REG_OFFSET_A_Y, 16'h7FFF);
		write_reg(REG_GAIN_LINEAR, 16'h0000);
		write_reg(REG_GAIN_ANGULAR, 16'h0000);
		write_reg(REG_DISTANCE_LIMIT, 16'h0000);
		random_phase(20, 0);
		drain();

		// random phases; each drain is a full pause until all results are in
		random_config();
		random_phase(130, 0);
		drain();
		random_config();
		random_phase(120, 47);
		drain();
		random_config();
		random_phase(120, 33);
		drain();
		random_config();
		random_phase(110, 0);
		drain();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS formation_goal_p_controller_core");
		end else begin
			if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
			$display("FAIL formation_goal_p_controller_core");
		end
		$finish;
	end
endmodule
